@@ sv/rtc_pkg.sv @@
`timescale 1ns / 1ps

package rtc_pkg;

   // fraction bits of the rotation entries
   localparam int FRAC_BITS = 12;

   // default depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // row and column codes
   localparam logic [1:0] ROW_TRANS = 2'd3;
   localparam logic [1:0] ROW_LAST_ROT = 2'd2;
   localparam logic [1:0] COL_LAST = 2'd2;

   // operand codes
   localparam logic OPERAND_PARENT = 1'b0;
   localparam logic OPERAND_CHILD = 1'b1;

   // command codes
   localparam logic CMD_COMPOSE = 1'b0;
   localparam logic CMD_INVERSE = 1'b1;

   typedef logic signed [15:0] elem_type;
   typedef logic [2:0][15:0] row_type;
   typedef row_type [3:0] mat_type;

   // one operation handed from front to back
   typedef struct packed {
      logic cmd;
      mat_type parent;
      mat_type child;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      PH_INV,
      PH_ROT,
      PH_TRANS
   } phase_type;

endpackage

@@ sv/rtc_if.sv @@
`timescale 1ns / 1ps

interface rtc_req_if;
   logic valid;
   logic ready;
   logic cmd;
   logic operand;
   logic [1:0] row;
   logic signed [15:0] x_value;
   logic signed [15:0] y_value;
   logic signed [15:0] z_value;
   logic last;

   modport source(output valid, cmd, operand, row, x_value, y_value, z_value, last,
      input ready);
   modport sink(input valid, cmd, operand, row, x_value, y_value, z_value, last,
      output ready);
endinterface

interface rtc_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] out_row;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_z;
   logic out_last;

   modport source(output valid, out_row, out_x, out_y, out_z, out_last, input ready);
   modport sink(input valid, out_row, out_x, out_y, out_z, out_last, output ready);
endinterface

@@ sv/rtc_front.sv @@
`timescale 1ns / 1ps

module rtc_front (
   input logic clock,
   input logic reset,
   rtc_req_if.sink req_if,
   input logic job_full,
   output logic job_push,
   output rtc_pkg::job_type job_data
);

   rtc_pkg::mat_type parent_ff, parent_in;
   rtc_pkg::mat_type child_ff, child_in;
   logic accept;

   assign req_if.ready = !job_full;
   assign accept = req_if.valid && req_if.ready;

   // row store update, this transfer's row included in the snapshot
   always_comb begin
      parent_in = parent_ff;
      child_in = child_ff;
      if (accept) begin
         if (req_if.operand == rtc_pkg::OPERAND_CHILD) begin
            child_in[req_if.row][0] = req_if.x_value;
            child_in[req_if.row][1] = req_if.y_value;
            child_in[req_if.row][2] = req_if.z_value;
         end else begin
            parent_in[req_if.row][0] = req_if.x_value;
            parent_in[req_if.row][1] = req_if.y_value;
            parent_in[req_if.row][2] = req_if.z_value;
         end
      end
   end

   // last row hands a full snapshot to the back end
   assign job_push = accept && req_if.last;
   assign job_data = '{cmd: req_if.cmd, parent: parent_in, child: child_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         parent_ff <= '0;
         child_ff <= '0;
      end else begin
         parent_ff <= parent_in;
         child_ff <= child_in;
      end
   end

endmodule

@@ sv/rtc_queue.sv @@
`timescale 1ns / 1ps

module rtc_queue #(
   parameter int DEPTH = rtc_pkg::QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   input logic push,
   input rtc_pkg::job_type push_data,
   input logic pop,
   output logic full,
   output logic empty,
   output rtc_pkg::job_type head_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

   rtc_pkg::job_type mem [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full = (count_ff == CntW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head_data = mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job pushed into a full queue");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job popped from an empty queue");

endmodule

@@ sv/rtc_back.sv @@
`timescale 1ns / 1ps

module rtc_back (
   input logic clock,
   input logic reset,
   input logic job_empty,
   input rtc_pkg::job_type job,
   output logic job_pop,
   rtc_rsp_if.source rsp_if
);

   localparam int FB = rtc_pkg::FRAC_BITS;

   rtc_pkg::back_state_type state_ff, state_in;
   rtc_pkg::phase_type phase_ff, phase_in;
   logic [1:0] r_ff, r_in;
   logic [1:0] col_ff, col_in;
   logic signed [31:0] prod_ff [3];
   logic signed [31:0] prod_in [3];
   rtc_pkg::row_type res_ff, res_in;
   rtc_pkg::row_type invt_ff, invt_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_row_ff, rsp_row_in;
   rtc_pkg::row_type rsp_data_ff, rsp_data_in;
   logic rsp_last_ff, rsp_last_in;

   rtc_pkg::elem_type mul_a [3];
   rtc_pkg::elem_type mul_b [3];
   logic [31:0] sum_full;
   logic [31:0] sum_neg;
   logic [15:0] sum_rot;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // multiplier operand select, one dot product of three terms per step
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         case (phase_ff)
            rtc_pkg::PH_INV: begin
               mul_a[k] = job.child[k][col_ff];
               mul_b[k] = job.child[rtc_pkg::ROW_TRANS][k];
            end
            rtc_pkg::PH_ROT: begin
               mul_a[k] = job.parent[r_ff][k];
               mul_b[k] = (job.cmd == rtc_pkg::CMD_INVERSE) ? job.child[col_ff][k]
                  : job.child[k][col_ff];
            end
            rtc_pkg::PH_TRANS: begin
               mul_a[k] = job.parent[col_ff][k];
               mul_b[k] = (job.cmd == rtc_pkg::CMD_INVERSE) ? invt_ff[k]
                  : job.child[rtc_pkg::ROW_TRANS][k];
            end
            default: begin
               mul_a[k] = '0;
               mul_b[k] = '0;
            end
         endcase
         prod_in[k] = mul_a[k] * mul_b[k];
      end
   end

   // sums of the registered products
   always_comb begin
      sum_full = 32'(prod_ff[0]) + 32'(prod_ff[1]) + 32'(prod_ff[2]);
      sum_neg = 32'd0 - sum_full;
      sum_rot = prod_ff[0][FB +: 16] + prod_ff[1][FB +: 16] + prod_ff[2][FB +: 16];
   end

   // sequencer: inverse translation (inverse command only), rotation rows, translation row
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      r_in = r_ff;
      col_in = col_ff;
      res_in = res_ff;
      invt_in = invt_ff;
      job_pop = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_row_in = rsp_row_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         rtc_pkg::ST_IDLE: begin
            if (!job_empty) begin
               phase_in = (job.cmd == rtc_pkg::CMD_INVERSE) ? rtc_pkg::PH_INV
                  : rtc_pkg::PH_ROT;
               r_in = '0;
               col_in = '0;
               state_in = rtc_pkg::ST_MUL;
            end
         end
         rtc_pkg::ST_MUL: begin
            state_in = rtc_pkg::ST_ACC;
         end
         rtc_pkg::ST_ACC: begin
            case (phase_ff)
               rtc_pkg::PH_INV: invt_in[col_ff] = sum_neg[FB +: 16];
               rtc_pkg::PH_ROT: res_in[col_ff] = sum_rot;
               rtc_pkg::PH_TRANS: res_in[col_ff] = sum_full[FB +: 16]
                  + job.parent[rtc_pkg::ROW_TRANS][col_ff];
               default: res_in = res_ff;
            endcase
            if (col_ff == rtc_pkg::COL_LAST) begin
               col_in = '0;
               if (phase_ff == rtc_pkg::PH_INV) begin
                  phase_in = rtc_pkg::PH_ROT;
                  state_in = rtc_pkg::ST_MUL;
               end else begin
                  state_in = rtc_pkg::ST_EMIT;
               end
            end else begin
               col_in = col_ff + 1'b1;
               state_in = rtc_pkg::ST_MUL;
            end
         end
         rtc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               if (phase_ff == rtc_pkg::PH_TRANS) begin
                  rsp_row_in = rtc_pkg::ROW_TRANS;
                  rsp_last_in = 1'b1;
                  job_pop = 1'b1;
                  state_in = rtc_pkg::ST_IDLE;
               end else begin
                  rsp_row_in = r_ff;
                  rsp_last_in = 1'b0;
                  state_in = rtc_pkg::ST_MUL;
                  if (r_ff == rtc_pkg::ROW_LAST_ROT) begin
                     phase_in = rtc_pkg::PH_TRANS;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = rtc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtc_pkg::ST_IDLE;
         phase_ff <= rtc_pkg::PH_ROT;
         r_ff <= '0;
         col_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         r_ff <= r_in;
         col_ff <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         prod_ff[k] <= prod_in[k];
      end
      res_ff <= res_in;
      invt_ff <= invt_in;
      rsp_row_ff <= rsp_row_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.out_row = rsp_row_ff;
   assign rsp_if.out_x = rtc_pkg::elem_type'(rsp_data_ff[0]);
   assign rsp_if.out_y = rtc_pkg::elem_type'(rsp_data_ff[1]);
   assign rsp_if.out_z = rtc_pkg::elem_type'(rsp_data_ff[2]);
   assign rsp_if.out_last = rsp_last_ff;

   a_busy_has_job: assert property (@(posedge clock) disable iff (reset)
      state_ff != rtc_pkg::ST_IDLE |-> !job_empty)
      else $error("back end busy without a queued job");
   a_last_is_trans: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_row_ff == rtc_pkg::ROW_TRANS)
      else $error("last result row is not the translation row");
   a_pop_with_last: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> rsp_valid_ff && rsp_last_ff)
      else $error("job retired without its translation row");

endmodule

@@ sv/rigid_transform_compose_q12.sv @@
`timescale 1ns / 1ps

// channel  dir  modport           payload
// req_if   in   rtc_req_if.sink   cmd, operand, row, x_value, y_value, z_value, last
// rsp_if   out  rtc_rsp_if.source out_row, out_x, out_y, out_z, out_last
//
// the front end takes one row per cycle while the job queue has room; a last row
// also queues a snapshot of both matrices
// the back end runs three 16x16 multipliers; each dot product first registers its
// three products, then sums them, and a job may also wait on rsp_if.ready
// a full output register holds the sequencer; rows keep loading meanwhile
// synchronous reset clears all rows to zero and empties the queue

module rigid_transform_compose_q12 #(
   parameter int QUEUE_DEPTH = rtc_pkg::QUEUE_DEPTH
) (
   input logic clock,
   input logic reset,
   rtc_req_if.sink req_if,
   rtc_rsp_if.source rsp_if
);

   logic job_push;
   logic job_pop;
   logic job_full;
   logic job_empty;
   rtc_pkg::job_type push_job;
   rtc_pkg::job_type head_job;

   rtc_front u_front (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .job_full(job_full),
      .job_push(job_push),
      .job_data(push_job)
   );

   rtc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .push_data(push_job),
      .pop(job_pop),
      .full(job_full),
      .empty(job_empty),
      .head_data(head_job)
   );

   rtc_back u_back (
      .clock(clock),
      .reset(reset),
      .job_empty(job_empty),
      .job(head_job),
      .job_pop(job_pop),
      .rsp_if(rsp_if)
   );

endmodule
